// ----- hw/rtl/ui_rect_clip_to_triangles_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle clip core
// Shared property forms; the user module supplies clk and rst.
// ----------------------------------------------------------------------------
`ifndef UI_RECT_CLIP_TO_TRIANGLES_CORE_DEFINES_SVH
`define UI_RECT_CLIP_TO_TRIANGLES_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent
`define URC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("urc assertion failed");

// Consequent must hold in the cycle the antecedent completes
`define URC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) ante |-> (cons)) \
    else $error("urc assertion failed");

`endif

// ----- hw/rtl/urc_pkg.sv -----
// ----------------------------------------------------------------------------
// urc_pkg
// Types, constants and helpers shared by the rectangle clip core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urc_pkg;

  // Default clip stack depth
  localparam int CLIP_DEPTH_DEF = 16;

  // Vertices emitted per drawn rectangle
  localparam int VERTS_PER_RECT = 6;

  // Hard limit on vertices per frame
  localparam logic [20:0] CAP_LIMIT = 21'd1048576;

  // Register reset values
  localparam logic [14:0] SCREEN_W_RST = 15'd10240;
  localparam logic [14:0] SCREEN_H_RST = 15'd7680;
  localparam logic [20:0] VCAP_RST     = 21'd1048576;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [1:0] CFG_VCAP     = 2'd2;

  // Command codes
  typedef enum logic [1:0] {
    MODE_RECT  = 2'd0,
    MODE_PUSH  = 2'd1,
    MODE_POP   = 2'd2,
    MODE_FRAME = 2'd3
  } mode_t;

  // One rectangle by its corners, also one clip stack entry
  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic signed [15:0] r;
    logic signed [15:0] b;
  } box_t;

  // Load request into the vertex generator
  typedef struct packed {
    logic        valid;
    box_t        box;
    logic [31:0] argb;
    logic [19:0] slot;
  } gen_load_t;

  // Signed 16-bit add with saturation
  function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
    logic signed [16:0] sum;
    logic signed [15:0] res;
    sum = {a[15], a} + {b[15], b};
    if (sum[16] != sum[15]) begin
      res = sum[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      res = sum[15:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/ui_rect_clip_to_triangles_core.sv -----
// ----------------------------------------------------------------------------
// ui_rect_clip_to_triangles_core
// Clips 2D rectangles against a clip stack and emits triangle-list vertices.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Beat
// in        input      in_valid/in_ready     one draw command
// out       output     out_valid/out_ready   one vertex
// cfg       input      cfg_valid/cfg_ready   one register write
//
// A command passes an accept stage, then a clip stage that sees the stack top
// in the cycle after its read; a drawn rectangle takes six output beats in the
// generator, which loads the next as its last beat leaves; other commands one
// per cycle when no rectangle waits. Stack writes from push and frame begin are
// forwarded to a read issued in the same cycle. Synchronous reset clears control
// state; the clip stack is not cleared. A stalled output holds the generator,
// and the clip stage waits only when it carries a rectangle to draw.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ui_rect_clip_to_triangles_core #(
  parameter int CLIP_DEPTH = urc_pkg::CLIP_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] width,
  input  logic signed [15:0] height,
  input  logic [31:0]        argb,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] vert_x,
  output logic signed [15:0] vert_y,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  output logic [19:0]        vert_slot,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [20:0]        cfg_data
);
  import urc_pkg::*;

  localparam int AW = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
  localparam int DW = $clog2(CLIP_DEPTH + 1);

  // Configuration registers
  logic [14:0] disp_width;
  logic [14:0] disp_height;
  logic [20:0] vcap;

  // Frame state
  logic [DW-1:0] depth;
  logic [20:0]   vertex_count;

  // Clip stack memory and its read port
  box_t          mem [CLIP_DEPTH];
  box_t          rd_data;
  logic          fwd_hit;
  box_t          fwd_data;

  // Clip stage registers
  logic          s1_valid;
  mode_t         s1_mode;
  box_t          s1_box;
  logic          s1_noclip;
  logic          s1_push_ok;
  logic [AW-1:0] s1_wr_addr;
  logic [31:0]   s1_argb;

  // Stage logic
  logic          in_fire;
  mode_t         in_mode;
  logic [AW-1:0] raddr;
  box_t          in_box;
  box_t          top;
  box_t          isect;
  logic          empty;
  box_t          clipped;
  box_t          push_box;
  logic [20:0]   cap;
  logic          room;
  logic          needs_gen;
  logic          gen_ready;
  logic          s1_go;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  box_t          wr_data;
  gen_load_t     load;

  assign cfg_ready = 1'b1;
  assign in_mode   = mode_t'(mode);
  assign in_ready  = !s1_valid || s1_go;
  assign in_fire   = in_valid && in_ready;

  // Read the current top; depth zero reads a don't-care entry
  assign raddr = (depth == '0) ? '0 : AW'(depth - DW'(1));

  // Corners of the incoming rectangle
  always_comb begin
    in_box.l = pos_x;
    in_box.t = pos_y;
    in_box.r = sat_add16(pos_x, width);
    in_box.b = sat_add16(pos_y, height);
  end

  // Intersect with the stack top, forwarded if just written
  always_comb begin
    top     = fwd_hit ? fwd_data : rd_data;
    isect.l = (s1_box.l > top.l) ? s1_box.l : top.l;
    isect.t = (s1_box.t > top.t) ? s1_box.t : top.t;
    isect.r = (s1_box.r < top.r) ? s1_box.r : top.r;
    isect.b = (s1_box.b < top.b) ? s1_box.b : top.b;
    empty   = (isect.r <= isect.l) || (isect.b <= isect.t);
    clipped = s1_noclip ? s1_box : isect;
    if (s1_noclip) begin
      push_box = s1_box;
    end else if (!empty) begin
      push_box = isect;
    end else begin
      push_box.l = s1_box.l;
      push_box.t = s1_box.t;
      push_box.r = s1_box.l;
      push_box.b = s1_box.t;
    end
  end

  // Check the vertex buffer for six more slots
  assign cap  = (vcap > CAP_LIMIT) ? CAP_LIMIT : vcap;
  assign room = ({1'b0, vertex_count} + 22'(VERTS_PER_RECT)) <= {1'b0, cap};

  assign needs_gen = (s1_mode == MODE_RECT) && (s1_noclip || !empty) && room;
  assign s1_go     = s1_valid && (!needs_gen || gen_ready);

  // Stack write from push or frame begin
  always_comb begin
    wr_en   = s1_go && (((s1_mode == MODE_PUSH) && s1_push_ok) || (s1_mode == MODE_FRAME));
    wr_addr = (s1_mode == MODE_FRAME) ? '0 : s1_wr_addr;
    if (s1_mode == MODE_FRAME) begin
      wr_data.l = '0;
      wr_data.t = '0;
      wr_data.r = {1'b0, disp_width};
      wr_data.b = {1'b0, disp_height};
    end else begin
      wr_data = push_box;
    end
  end

  // Hand a drawn rectangle to the generator
  always_comb begin
    load.valid = s1_go && needs_gen;
    load.box   = clipped;
    load.argb  = s1_argb;
    load.slot  = vertex_count[19:0];
  end

  // Clip stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      rd_data <= mem[raddr];
    end
  end

  // Control state, config, accept and clip stages
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_width   <= SCREEN_W_RST;
      disp_height  <= SCREEN_H_RST;
      vcap         <= VCAP_RST;
      depth        <= '0;
      vertex_count <= '0;
      s1_valid     <= 1'b0;
      fwd_hit      <= 1'b0;
    end else begin
      // Take register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SCREEN_W: disp_width  <= cfg_data[14:0];
          CFG_SCREEN_H: disp_height <= cfg_data[14:0];
          CFG_VCAP:     vcap        <= cfg_data;
          default: ;
        endcase
      end

      // Advance the vertex count as the clip stage retires
      if (s1_go) begin
        if (s1_mode == MODE_FRAME) begin
          vertex_count <= '0;
        end else if (needs_gen) begin
          vertex_count <= vertex_count + 21'(VERTS_PER_RECT);
        end
      end

      // Accept a beat: update depth, capture the command
      if (in_fire) begin
        s1_valid   <= 1'b1;
        s1_mode    <= in_mode;
        s1_box     <= in_box;
        s1_argb    <= argb;
        s1_noclip  <= (depth == '0);
        s1_push_ok <= (depth < DW'(CLIP_DEPTH));
        s1_wr_addr <= AW'(depth);
        fwd_hit    <= wr_en && (wr_addr == raddr);
        fwd_data   <= wr_data;
        unique case (in_mode)
          MODE_PUSH:  if (depth < DW'(CLIP_DEPTH)) depth <= depth + DW'(1);
          MODE_POP:   if (depth > DW'(1)) depth <= depth - DW'(1);
          MODE_FRAME: depth <= DW'(1);
          default: ;
        endcase
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  urc_vert_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .ready     (gen_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vert_x    (vert_x),
    .vert_y    (vert_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .vert_slot (vert_slot),
    .last      (last)
  );

endmodule

// ----- hw/rtl/urc_vert_gen.sv -----
// ----------------------------------------------------------------------------
// urc_vert_gen
// Output register stage: turns one clipped rectangle into six vertex beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urc_vert_gen (
  input  logic               clk,
  input  logic               rst,
  input  urc_pkg::gen_load_t load,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] vert_x,
  output logic signed [15:0] vert_y,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  output logic [19:0]        vert_slot,
  output logic               last
);
  import urc_pkg::*;

  localparam logic [2:0] BEAT_LAST = 3'(VERTS_PER_RECT - 1);

  logic        busy;
  logic [2:0]  beat;
  box_t        box;
  logic [31:0] argb;
  logic [19:0] slot;
  logic        at_right;
  logic        at_bottom;

  // Free now, or freed by the last beat leaving this cycle
  assign ready = !busy || (out_ready && beat == BEAT_LAST);

  // Hold the rectangle and step through its vertices
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= '0;
    end else if (load.valid) begin
      busy <= 1'b1;
      beat <= '0;
      box  <= load.box;
      argb <= load.argb;
      slot <= load.slot;
    end else if (busy && out_ready) begin
      if (beat == BEAT_LAST) begin
        busy <= 1'b0;
      end else begin
        beat <= beat + 3'd1;
        slot <= slot + 20'd1;
      end
    end
  end

  // Corner order: LT, RT, LB, LB, RT, RB
  always_comb begin
    case (beat)
      3'd1, 3'd4: begin
        at_right  = 1'b1;
        at_bottom = 1'b0;
      end
      3'd2, 3'd3: begin
        at_right  = 1'b0;
        at_bottom = 1'b1;
      end
      3'd5: begin
        at_right  = 1'b1;
        at_bottom = 1'b1;
      end
      default: begin
        at_right  = 1'b0;
        at_bottom = 1'b0;
      end
    endcase
  end

  assign out_valid = busy;
  assign vert_x    = at_right ? box.r : box.l;
  assign vert_y    = at_bottom ? box.b : box.t;
  assign alpha     = argb[31:24];
  assign red       = argb[23:16];
  assign green     = argb[15:8];
  assign blue      = argb[7:0];
  assign vert_slot = slot;
  assign last      = (beat == BEAT_LAST);

endmodule

// ----- hw/rtl/urc_checker.sv -----
// ----------------------------------------------------------------------------
// urc_checker
// Port-level checks on the vertex stream of the rectangle clip core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ui_rect_clip_to_triangles_core_defines.svh"

module urc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] vert_x,
  input logic [19:0]        vert_slot,
  input logic               last
);

  // A stalled vertex beat holds its slot
  `URC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                   out_valid && $stable(vert_slot))

  // Vertices of one rectangle follow without a gap, in consecutive slots
  `URC_ASSERT_NEXT(a_slot_step, out_valid && out_ready && !last,
                   out_valid && (vert_slot == $past(vert_slot) + 20'd1))

  // The sixth vertex shares its x with the fifth
  `URC_ASSERT_SAME(a_last_x, out_valid && out_ready && !last ##1 out_valid && last,
                   vert_x == $past(vert_x))

endmodule

bind ui_rect_clip_to_triangles_core urc_checker u_urc_checker (.*);
